>>> src/ial_pkg.sv
package ial_pkg;

  // default sizes handed to the top level
  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int LINE_BITS_DEF     = 24;

  // token queue between classifier and output stage (power of two, at least 2)
  localparam int QUEUE_DEPTH = 4;

  localparam int KIND_BITS = 5;
  localparam int CHAR_BITS = 8;

  // keyword table: text left aligned in an 8-character slot, padded with spaces
  localparam int KW_COUNT = 11;
  localparam int KW_SLOT  = 8;

  typedef enum logic [KIND_BITS-1:0] {
    TK_DELIM    = 5'd0,
    TK_PUNCT    = 5'd1,
    TK_NUMBER   = 5'd2,
    TK_IDENT    = 5'd3,
    TK_BREAK    = 5'd4,
    TK_CONTINUE = 5'd5,
    TK_ELIF     = 5'd6,
    TK_ELSE     = 5'd7,
    TK_FUNC     = 5'd8,
    TK_IF       = 5'd9,
    TK_LOOP     = 5'd10,
    TK_NUM      = 5'd11,
    TK_RETURN   = 5'd12,
    TK_STR      = 5'd13,
    TK_VOID     = 5'd14,
    TK_UNKNOWN  = 5'd15,
    TK_END      = 5'd16
  } kind_t;

  // what the held token is while the next byte decides how it ends
  typedef enum logic [3:0] {
    PC_NONE,
    PC_NUM,
    PC_IDENT,
    PC_BANG,
    PC_AMP,
    PC_PIPE,
    PC_LT,
    PC_GT,
    PC_MINUS,
    PC_NL,
    PC_SPACES
  } pclass_t;

  // queue write strobes for the up to two tokens of one byte
  typedef struct packed {
    logic first_valid;
    logic second_valid;
  } push_t;

  localparam logic [8*KW_SLOT-1:0] KW_TEXT [KW_COUNT] = '{
    "break   ", "continue", "elif    ", "else    ", "func    ", "if      ",
    "loop    ", "num     ", "return  ", "str     ", "void    "
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd8, 4'd4, 4'd4, 4'd4, 4'd2, 4'd4, 4'd3, 4'd6, 4'd3, 4'd4
  };

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
  endfunction

  // single-character punctuators
  function automatic logic is_symbol(input logic [CHAR_BITS-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      ":", "=", "^", "~", "+", "/", "*", "%", "(", ")", "[", "]", ",": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

>>> src/indent_aware_source_lexer.sv
// Source lexer for an indentation-aware language.
// Input channel s_*: one source byte per transfer in s_tdata[7:0]; s_tuser
// set (or a zero byte) marks end of text, which flushes the held token and
// produces an end marker with m_tlast set. The lexer then starts a new text.
// Output channel m_*: one token per transfer, with kind, length, first
// character and line number packed in m_tdata.
// A token passes from the classifier through the token queue into the output
// register. Throughput: one byte per cycle while s_tready is high. A byte
// yields zero, one or two tokens; the classifier writes both into a
// four-entry token queue, and the output stage drains one token per cycle
// while m_tready is high, so a run of two-token bytes is bounded by that
// single output port and s_tready drops while fewer than two slots are free.
// When the receiver stalls, m_tdata and m_tlast hold, the queue fills and
// s_tready falls; nothing is dropped.
// Reset clears the queue and output valid and returns the lexer to line one,
// start of line, nothing held. No clearing pass is needed.
module indent_aware_source_lexer import ial_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  parameter int LINE_BITS     = LINE_BITS_DEF,
  localparam int DATA_W = ((KIND_BITS + LENGTH_BITS + CHAR_BITS + LINE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // text_byte
  input  logic              s_tuser,   // end_of_text
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // token_kind, token_length, first_char, line_number
  output logic              m_tlast    // last_token
);

  localparam int ENTRY_W = KIND_BITS + LENGTH_BITS + CHAR_BITS + LINE_BITS + 1
                           + KEYWORD_CHARS * CHAR_BITS;

  push_t              push;
  logic [ENTRY_W-1:0] entry0;
  logic [ENTRY_W-1:0] entry1;
  logic               room;
  logic               pop;
  logic [ENTRY_W-1:0] head;
  logic               nonempty;

  // byte classifier and pending token state
  ial_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .LENGTH_BITS  (LENGTH_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_byte (s_tdata),
    .in_end  (s_tuser),
    .room    (room),
    .push    (push),
    .entry0  (entry0),
    .entry1  (entry1)
  );

  // token queue
  ial_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din0    (entry0),
    .din1    (entry1),
    .room    (room),
    .pop     (pop),
    .head    (head),
    .nonempty(nonempty)
  );

  // keyword resolution and output register
  ial_back #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .LENGTH_BITS  (LENGTH_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .nonempty(nonempty),
    .head    (head),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

>>> src/ial_front.sv
module ial_front import ial_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  parameter int LINE_BITS     = LINE_BITS_DEF,
  localparam int ENTRY_W = KIND_BITS + LENGTH_BITS + CHAR_BITS + LINE_BITS + 1
                           + KEYWORD_CHARS * CHAR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_BITS-1:0] in_byte,
  input  logic                 in_end,
  input  logic                 room,
  output push_t                push,
  output logic [ENTRY_W-1:0]   entry0,
  output logic [ENTRY_W-1:0]   entry1
);

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

  // pending token state
  pclass_t                pclass, pclass_next;
  logic [LENGTH_BITS-1:0] plen, plen_next;
  logic [CHAR_BITS-1:0]   pfirst, pfirst_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic                   indent, indent_next;
  logic                   space_odd, space_odd_next;
  logic [CHAR_BITS-1:0]   prefix [KEYWORD_CHARS];
  logic [KEYWORD_CHARS*CHAR_BITS-1:0] prefix_flat;
  logic                   prefix_we;
  logic                   prefix_start;

  logic                   accept;
  logic                   fin;
  logic [CHAR_BITS-1:0]   nxt;
  logic                   ext;

  // token that the pending state turns into
  logic                   fl_valid;
  kind_t                  fl_kind;
  logic [LENGTH_BITS-1:0] fl_len;
  logic                   fl_two;
  logic                   indent_fl;

  // token or pending class that a fresh byte starts
  logic                   st_valid;
  kind_t                  st_kind;
  pclass_t                st_class;

  logic [LENGTH_BITS-1:0] plen_sat;
  logic [LINE_BITS-1:0]   line_sat;

  function automatic logic [ENTRY_W-1:0] pack_entry(
    input kind_t                              k,
    input logic [LENGTH_BITS-1:0]             len,
    input logic [CHAR_BITS-1:0]               f,
    input logic                               last,
    input logic [LINE_BITS-1:0]               ln,
    input logic [KEYWORD_CHARS*CHAR_BITS-1:0] pfx
  );
    return {pfx, last, ln, f, len, k};
  endfunction

  assign in_ready = room;
  assign accept   = in_valid && room;

  // flatten the stored identifier prefix for the queue
  always_comb begin
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      prefix_flat[i*CHAR_BITS +: CHAR_BITS] = prefix[i];
    end
  end

  assign plen_sat = (plen == '1) ? plen : plen + LEN_ONE;
  assign line_sat = (line == '1) ? line : line + LINE_BITS'(1);

  // classify the byte against the pending token
  always_comb begin
    fin = in_end || (in_byte == '0);
    nxt = fin ? '0 : in_byte;

    fl_valid = 1'b0;
    fl_kind  = TK_PUNCT;
    fl_len   = LEN_ONE;
    fl_two   = 1'b0;
    case (pclass)
      PC_NUM: begin
        fl_valid = 1'b1;
        fl_kind  = TK_NUMBER;
        fl_len   = plen;
      end
      PC_IDENT: begin
        fl_valid = 1'b1;
        fl_kind  = TK_IDENT;
        fl_len   = plen;
      end
      PC_BANG: begin
        fl_valid = 1'b1;
        fl_two   = (nxt == "=");
        fl_kind  = fl_two ? TK_PUNCT : TK_UNKNOWN;
      end
      PC_AMP: begin
        fl_valid = 1'b1;
        fl_two   = (nxt == "&");
      end
      PC_PIPE: begin
        fl_valid = 1'b1;
        fl_two   = (nxt == "|");
      end
      PC_LT: begin
        fl_valid = 1'b1;
        fl_two   = (nxt == "<") || (nxt == "=");
      end
      PC_GT: begin
        fl_valid = 1'b1;
        fl_two   = (nxt == ">") || (nxt == "=");
      end
      PC_MINUS: begin
        fl_valid = 1'b1;
        fl_two   = (nxt == ">");
      end
      PC_NL: begin
        fl_valid = 1'b1;
        fl_kind  = (nxt == "\n") ? TK_DELIM : TK_PUNCT;
      end
      PC_SPACES: begin
        fl_valid = 1'b1;
        fl_kind  = space_odd ? TK_UNKNOWN : TK_PUNCT;
        fl_len   = plen;
      end
      default: fl_valid = 1'b0;
    endcase
    if (fl_two) begin
      fl_len = LEN_TWO;
    end

    // indent mode follows the last token emitted
    indent_fl = fl_valid ? ((fl_kind == TK_PUNCT) && (pfirst == "\n")) : indent;

    st_valid = 1'b0;
    st_kind  = TK_UNKNOWN;
    st_class = PC_NONE;
    if (is_digit(in_byte)) begin
      st_class = PC_NUM;
    end else if (is_alpha(in_byte)) begin
      st_class = PC_IDENT;
    end else begin
      case (in_byte)
        "!":  st_class = PC_BANG;
        "&":  st_class = PC_AMP;
        "|":  st_class = PC_PIPE;
        "<":  st_class = PC_LT;
        ">":  st_class = PC_GT;
        "-":  st_class = PC_MINUS;
        "\n": st_class = PC_NL;
        " ": begin
          if (indent_fl) begin
            st_class = PC_SPACES;
          end else begin
            st_valid = 1'b1;
            st_kind  = TK_DELIM;
          end
        end
        default: begin
          st_valid = 1'b1;
          st_kind  = is_symbol(in_byte) ? TK_PUNCT : TK_UNKNOWN;
        end
      endcase
    end

    ext = ((pclass == PC_NUM) && is_digit(in_byte))
       || ((pclass == PC_IDENT) && (is_alpha(in_byte) || is_digit(in_byte)))
       || ((pclass == PC_SPACES) && (in_byte == " "));
  end

  // next state and queue writes
  always_comb begin
    pclass_next    = pclass;
    plen_next      = plen;
    pfirst_next    = pfirst;
    line_next      = line;
    indent_next    = indent;
    space_odd_next = space_odd;
    prefix_we      = 1'b0;
    prefix_start   = 1'b0;
    push           = '0;
    entry0 = pack_entry(fl_kind, fl_len, pfirst, 1'b0, line, prefix_flat);
    entry1 = pack_entry(st_kind, LEN_ONE, in_byte, 1'b0, line, prefix_flat);

    if (accept) begin
      if (fin) begin
        // flush, end marker, back to the start of a text
        pclass_next    = PC_NONE;
        plen_next      = '0;
        pfirst_next    = '0;
        line_next      = LINE_BITS'(1);
        indent_next    = 1'b1;
        space_odd_next = 1'b0;
        push.first_valid = 1'b1;
        if (fl_valid) begin
          push.second_valid = 1'b1;
          entry1 = pack_entry(TK_END, '0, '0, 1'b1, line, prefix_flat);
        end else begin
          entry0 = pack_entry(TK_END, '0, '0, 1'b1, line, prefix_flat);
        end
      end else if (ext) begin
        // byte grows the pending run
        plen_next = plen_sat;
        if (pclass == PC_SPACES) begin
          space_odd_next = !space_odd;
        end
        prefix_we = (pclass == PC_IDENT) && (plen < LENGTH_BITS'(KEYWORD_CHARS));
      end else if (fl_two) begin
        // second character of a two-character operator
        pclass_next      = PC_NONE;
        indent_next      = 1'b0;
        push.first_valid = 1'b1;
      end else begin
        pclass_next = st_class;
        plen_next   = LEN_ONE;
        pfirst_next = in_byte;
        indent_next = st_valid ? 1'b0 : indent_fl;
        if (st_class == PC_NL) begin
          line_next = line_sat;
        end
        if (st_class == PC_SPACES) begin
          space_odd_next = 1'b1;
        end
        prefix_start = (st_class == PC_IDENT);
        if (fl_valid) begin
          push.first_valid  = 1'b1;
          push.second_valid = st_valid;
        end else if (st_valid) begin
          push.first_valid = 1'b1;
          entry0 = pack_entry(st_kind, LEN_ONE, in_byte, 1'b0, line, prefix_flat);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pclass    <= PC_NONE;
      plen      <= '0;
      pfirst    <= '0;
      line      <= LINE_BITS'(1);
      indent    <= 1'b1;
      space_odd <= 1'b0;
    end else begin
      pclass    <= pclass_next;
      plen      <= plen_next;
      pfirst    <= pfirst_next;
      line      <= line_next;
      indent    <= indent_next;
      space_odd <= space_odd_next;
    end
  end

  // first identifier characters for keyword matching
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (prefix_start && (i == 0)) begin
        prefix[i] <= in_byte;
      end else if (prefix_we && (plen == LENGTH_BITS'(i))) begin
        prefix[i] <= in_byte;
      end
    end
  end

endmodule

>>> src/ial_queue.sv
module ial_queue import ial_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic [WIDTH-1:0] din0,
  input  logic [WIDTH-1:0] din1,
  output logic             room,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             nonempty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic [1:0]       nwr;

  assign nwr      = {1'b0, push.first_valid} + {1'b0, push.second_valid};
  assign room     = (count <= CW'(DEPTH - 2));
  assign nonempty = (count != '0);
  assign head     = mem[rptr];

  // storage, up to two writes per cycle at consecutive slots
  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wptr] <= din0;
    end
    if (push.second_valid) begin
      mem[wptr + AW'(1)] <= din1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(nwr);
      rptr  <= rptr + AW'(pop);
      count <= count + CW'(nwr) - CW'(pop);
    end
  end

endmodule

>>> src/ial_back.sv
module ial_back import ial_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  parameter int LINE_BITS     = LINE_BITS_DEF,
  localparam int ENTRY_W = KIND_BITS + LENGTH_BITS + CHAR_BITS + LINE_BITS + 1
                           + KEYWORD_CHARS * CHAR_BITS,
  localparam int DATA_W  = ((KIND_BITS + LENGTH_BITS + CHAR_BITS + LINE_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  logic [ENTRY_W-1:0] head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [DATA_W-1:0]  m_tdata,
  output logic               m_tlast
);

  localparam int LEN_OFF   = KIND_BITS;
  localparam int FIRST_OFF = LEN_OFF + LENGTH_BITS;
  localparam int LINE_OFF  = FIRST_OFF + CHAR_BITS;
  localparam int LAST_OFF  = LINE_OFF + LINE_BITS;
  localparam int PFX_OFF   = LAST_OFF + 1;

  kind_t                  head_kind;
  logic [LENGTH_BITS-1:0] head_len;
  logic [CHAR_BITS-1:0]   head_first;
  logic [LINE_BITS-1:0]   head_line;
  logic                   head_last;
  kind_t                  kind_res;
  logic                   found;
  logic                   match;

  assign head_kind  = kind_t'(head[KIND_BITS-1:0]);
  assign head_len   = head[LEN_OFF +: LENGTH_BITS];
  assign head_first = head[FIRST_OFF +: CHAR_BITS];
  assign head_line  = head[LINE_OFF +: LINE_BITS];
  assign head_last  = head[LAST_OFF];

  // identifiers that spell a keyword get the keyword kind
  always_comb begin
    kind_res = head_kind;
    found    = 1'b0;
    match    = 1'b0;
    if (head_kind == TK_IDENT) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        match = (head_len == LENGTH_BITS'(KW_LEN[k]));
        for (int i = 0; i < KW_SLOT; i++) begin
          if ((i < int'(KW_LEN[k])) &&
              (head[PFX_OFF + i*CHAR_BITS +: CHAR_BITS] !=
               KW_TEXT[k][(KW_SLOT-1-i)*CHAR_BITS +: CHAR_BITS])) begin
            match = 1'b0;
          end
        end
        if (match && !found) begin
          found    = 1'b1;
          kind_res = kind_t'(KIND_BITS'(int'(TK_BREAK) + k));
        end
      end
    end
  end

  // output register, refilled whenever it is empty or its transfer completes
  assign pop = nonempty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= DATA_W'({head_line, head_first, head_len, kind_res});
      m_tlast <= head_last;
    end
  end

endmodule

>>> src/ial_checker.sv
module ial_checker import ial_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  localparam int DATA_W = ((KIND_BITS + LENGTH_BITS + CHAR_BITS + LINE_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tlast
);

  localparam int LEN_OFF  = KIND_BITS;
  localparam int LINE_OFF = KIND_BITS + LENGTH_BITS + CHAR_BITS;

  // nothing offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("token offered right after reset");

  // stalled token holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled token changed");

  // only the end marker carries last, and it alone has zero length
  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[KIND_BITS-1:0] == TK_END)) &&
                 (m_tlast == (m_tdata[LEN_OFF +: LENGTH_BITS] == '0)))
    else $error("end marker fields inconsistent");

  // line numbers start at one
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[LINE_OFF +: LINE_BITS] != '0)
    else $error("token with line number zero");

endmodule

bind indent_aware_source_lexer ial_checker #(
  .LENGTH_BITS(LENGTH_BITS),
  .LINE_BITS  (LINE_BITS)
) u_ial_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
